FILE: design/dcd_pkg.sv
// ----------------------------------------------------------------------------
// dcd_pkg
// Shared types, codes and helpers for the clock display controller.
// ----------------------------------------------------------------------------
package dcd_pkg;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 2;
  typedef logic [CFG_IDX_W-1:0] cfg_index_t;
  localparam cfg_index_t CFG_TICKS_PER_SECOND = 2'd0;
  localparam cfg_index_t CFG_AUTO_RETURN      = 2'd1;

  localparam logic [9:0] TPS_RESET = 10'd100;
  localparam logic [9:0] ART_RESET = 10'd500;

  // set mode codes
  localparam logic [1:0] MODE_NORMAL = 2'd0;
  localparam logic [1:0] MODE_HOUR   = 2'd1;
  localparam logic [1:0] MODE_MINUTE = 2'd2;
  localparam logic [1:0] MODE_SECOND = 2'd3;

  // button bit positions
  localparam int unsigned BTN_SET  = 0;
  localparam int unsigned BTN_UP   = 1;
  localparam int unsigned BTN_DOWN = 2;
  localparam int unsigned BTN_VIEW = 3;

  // display constants
  localparam logic [7:0] SEG_MINUS      = 8'h40;
  localparam logic [7:0] SEG_POINT      = 8'h80;
  localparam logic [7:0] SEG_BLANK      = 8'h00;
  localparam logic [7:0] CMD_DISPLAY_ON = 8'h88;

  // lowest accepted sample is above this value
  localparam logic signed [11:0] TEMP_FLOOR = -12'sd1600;

  typedef struct packed {
    logic [3:0]         buttons;
    logic               temp_valid;
    logic signed [11:0] temp_raw;
  } in_word_t;

  typedef struct packed {
    logic [7:0] digit_one;
    logic [7:0] digit_two;
    logic [7:0] digit_three;
    logic [7:0] digit_four;
    logic [7:0] display_cmd;
    logic [1:0] set_mode;
    logic       showing_time;
  } out_word_t;

  // seven-segment pattern of one decimal digit
  function automatic logic [7:0] seg_of(input logic [3:0] d);
    logic [7:0] s;
    case (d)
      4'd0:    s = 8'h3F;
      4'd1:    s = 8'h06;
      4'd2:    s = 8'h5B;
      4'd3:    s = 8'h4F;
      4'd4:    s = 8'h66;
      4'd5:    s = 8'h6D;
      4'd6:    s = 8'h7D;
      4'd7:    s = 8'h07;
      4'd8:    s = 8'h7F;
      4'd9:    s = 8'h6F;
      default: s = 8'h00;
    endcase
    return s;
  endfunction

  // leading decimal digit of v below 10*unit, by parallel compares
  function automatic logic [3:0] lead_digit(input logic [9:0] v, input logic [9:0] unit);
    logic [3:0] d;
    d = 4'd0;
    for (int k = 1; k < 10; k++) begin
      if ({4'd0, v} >= 14'(k) * {4'd0, unit}) d = 4'(k);
    end
    return d;
  endfunction

  // step a field up or down, wrapping within 0..top
  function automatic logic [5:0] step_wrap(input logic [5:0] v, input logic [5:0] top,
                                           input logic up);
    logic [5:0] r;
    if (up) r = (v == top) ? 6'd0 : v + 6'd1;
    else    r = (v == 6'd0) ? top : v - 6'd1;
    return r;
  endfunction

endpackage

FILE: design/digital_clock_display_controller.sv
// ----------------------------------------------------------------------------
// digital_clock_display_controller
// 24-hour clock with button handling and a four-digit seven-segment frame.
// ----------------------------------------------------------------------------
// Usage: each input word is one 10 ms tick with the raw button levels and an
// optional temperature sample. Every accepted word yields exactly one output
// word: four segment bytes, the display command, the set mode and the view.
// The output word is valid in the cycle after the input word is accepted.
// Throughput is one word per cycle while out_ready is high; the output register
// is the only stage, so in_ready stays high while it is empty or being taken.
// When the receiver holds out_ready low the output word is held and in_ready
// drops until it is taken; no word is lost or repeated.
// Temperature digits are split when the sample is stored, so the frame
// logic is a plain select of ready digits.
// Configuration words (ticks per second, auto-return ticks) are taken at any
// time on the cfg channel, whose ready is always high; indexes beyond the
// register list are ignored.
// Reset (rst_n low, synchronous) sets the time to 12:30:00, brightness 5,
// time view, 25.0 degrees stored, and empties the output register.
// ----------------------------------------------------------------------------
module digital_clock_display_controller (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  dcd_pkg::in_word_t   in_word,
  output logic                out_valid,
  input  logic                out_ready,
  output dcd_pkg::out_word_t  out_word,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  dcd_pkg::cfg_index_t cfg_index,
  input  logic [9:0]          cfg_data
);
  import dcd_pkg::*;

  // configuration
  logic [9:0] tps_r, art_r;

  // time keeping and control state
  logic [9:0] sub_r, sub_nxt;
  logic [5:0] sec_r, sec_nxt;
  logic [5:0] min_r, min_nxt;
  logic [4:0] hr_r, hr_nxt;
  logic [1:0] mode_r, mode_nxt;
  logic [2:0] bright_r, bright_nxt;
  logic       tview_r, tview_nxt;
  logic [9:0] rc_r, rc_nxt;
  logic [3:0] prev_btn_r;

  // stored temperature, already split into display digits
  logic       t_neg_r, t_neg_nxt;
  logic       t_thou_r, t_thou_nxt;
  logic [3:0] t_hund_r, t_hund_nxt;
  logic [3:0] t_tens_r, t_tens_nxt;
  logic [3:0] t_ones_r, t_ones_nxt;

  // output register
  logic       out_valid_r;
  out_word_t  out_word_r, out_word_nxt;

  // working signals
  logic [9:0]  sub_inc;
  logic [3:0]  pressed;
  logic        tview_btn;
  logic [9:0]  rc_btn, rc_inc;
  logic        up_dir;
  logic [2:0]  hr_tens, min_tens;
  logic [5:0]  hr_ones, min_ones;
  logic [11:0] t_abs;
  logic [15:0] t_x10;
  logic [10:0] t_mag;
  logic [9:0]  t_rem1, t_rem2;
  logic        accept;

  assign in_ready  = !out_valid_r || out_ready;
  assign accept    = in_valid && in_ready;
  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

  // tick processing
  always_comb begin
    sub_nxt    = sub_r;
    sec_nxt    = sec_r;
    min_nxt    = min_r;
    hr_nxt     = hr_r;
    mode_nxt   = mode_r;
    bright_nxt = bright_r;
    tview_btn  = tview_r;
    rc_btn     = rc_r;

    // advance time with carries
    sub_inc = sub_r + 10'd1;
    if (sub_inc >= tps_r) begin
      sub_nxt = '0;
      if (sec_r == 6'd59) begin
        sec_nxt = '0;
        if (min_r == 6'd59) begin
          min_nxt = '0;
          hr_nxt  = (hr_r == 5'd23) ? 5'd0 : hr_r + 5'd1;
        end else begin
          min_nxt = min_r + 6'd1;
        end
      end else begin
        sec_nxt = sec_r + 6'd1;
      end
    end else begin
      sub_nxt = sub_inc;
    end

    // press edges, first of set, up, down, view wins
    pressed = in_word.buttons & ~prev_btn_r;
    up_dir  = pressed[BTN_UP];
    if (pressed[BTN_SET]) begin
      mode_nxt = mode_r + 2'd1;
    end else if (pressed[BTN_UP] || pressed[BTN_DOWN]) begin
      case (mode_r)
        MODE_HOUR:   hr_nxt  = 5'(step_wrap({1'b0, hr_nxt}, 6'd23, up_dir));
        MODE_MINUTE: min_nxt = step_wrap(min_nxt, 6'd59, up_dir);
        MODE_SECOND: sec_nxt = step_wrap(sec_nxt, 6'd59, up_dir);
        default:     bright_nxt = up_dir ? bright_r + 3'd1 : bright_r - 3'd1;
      endcase
    end else if (pressed[BTN_VIEW]) begin
      tview_btn = !tview_r;
      rc_btn    = '0;
    end

    // frame from the updated time and mode state and the stored temperature digits
    hr_tens  = 3'(lead_digit({5'd0, hr_nxt}, 10'd10));
    hr_ones  = {1'b0, hr_nxt} - ({hr_tens, 3'd0} + {2'd0, hr_tens, 1'b0});
    min_tens = 3'(lead_digit({4'd0, min_nxt}, 10'd10));
    min_ones = min_nxt - ({min_tens, 3'd0} + {2'd0, min_tens, 1'b0});

    if (mode_nxt != MODE_NORMAL || tview_btn) begin
      out_word_nxt.digit_one   = seg_of({1'b0, hr_tens});
      out_word_nxt.digit_two   = seg_of(hr_ones[3:0]) | (sec_nxt[0] ? SEG_BLANK : SEG_POINT);
      out_word_nxt.digit_three = seg_of({1'b0, min_tens});
      out_word_nxt.digit_four  = seg_of(min_ones[3:0]);
    end else begin
      if (t_neg_r)       out_word_nxt.digit_one = SEG_MINUS;
      else if (t_thou_r) out_word_nxt.digit_one = seg_of(4'd1);
      else               out_word_nxt.digit_one = SEG_BLANK;
      out_word_nxt.digit_two   = seg_of(t_hund_r);
      out_word_nxt.digit_three = seg_of(t_tens_r) | SEG_POINT;
      out_word_nxt.digit_four  = seg_of(t_ones_r);
    end
    out_word_nxt.display_cmd  = CMD_DISPLAY_ON | {5'd0, bright_nxt};
    out_word_nxt.set_mode     = mode_nxt;
    out_word_nxt.showing_time = tview_btn;

    // sample magnitude in tenths, truncated toward zero, then split
    t_abs  = in_word.temp_raw[11] ? 12'(-in_word.temp_raw) : 12'(in_word.temp_raw);
    t_x10  = {1'b0, t_abs, 3'd0} + {3'd0, t_abs, 1'b0};
    t_mag  = t_x10[14:4];
    t_thou_nxt = t_mag >= 11'd1000;
    t_rem1     = t_thou_nxt ? 10'(t_mag - 11'd1000) : t_mag[9:0];
    t_hund_nxt = lead_digit(t_rem1, 10'd100);
    t_rem2     = t_rem1 - 10'(14'(t_hund_nxt) * 14'd100);
    t_tens_nxt = lead_digit(t_rem2, 10'd10);
    t_ones_nxt = 4'(t_rem2 - 10'(14'(t_tens_nxt) * 14'd10));
    t_neg_nxt  = in_word.temp_raw[11];

    // auto return to time view
    tview_nxt = tview_btn;
    rc_nxt    = rc_btn;
    rc_inc    = rc_btn + 10'd1;
    if (!tview_btn) begin
      if (rc_inc >= art_r) begin
        tview_nxt = 1'b1;
        rc_nxt    = '0;
      end else begin
        rc_nxt = rc_inc;
      end
    end
  end

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tps_r <= TPS_RESET;
      art_r <= ART_RESET;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        CFG_TICKS_PER_SECOND: tps_r <= cfg_data;
        CFG_AUTO_RETURN:      art_r <= cfg_data;
        default:              ;
      endcase
    end
  end

  // state update on each accepted word
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sub_r      <= '0;
      sec_r      <= '0;
      min_r      <= 6'd30;
      hr_r       <= 5'd12;
      mode_r     <= MODE_NORMAL;
      bright_r   <= 3'd5;
      tview_r    <= 1'b1;
      rc_r       <= '0;
      prev_btn_r <= '0;
      t_neg_r    <= 1'b0;
      t_thou_r   <= 1'b0;
      t_hund_r   <= 4'd2;
      t_tens_r   <= 4'd5;
      t_ones_r   <= 4'd0;
    end else if (accept) begin
      sub_r      <= sub_nxt;
      sec_r      <= sec_nxt;
      min_r      <= min_nxt;
      hr_r       <= hr_nxt;
      mode_r     <= mode_nxt;
      bright_r   <= bright_nxt;
      tview_r    <= tview_nxt;
      rc_r       <= rc_nxt;
      prev_btn_r <= in_word.buttons;
      if (in_word.temp_valid && (in_word.temp_raw > TEMP_FLOOR)) begin
        t_neg_r  <= t_neg_nxt;
        t_thou_r <= t_thou_nxt;
        t_hund_r <= t_hund_nxt;
        t_tens_r <= t_tens_nxt;
        t_ones_r <= t_ones_nxt;
      end
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (accept) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      out_word_r <= out_word_nxt;
    end
  end

`ifndef SYNTHESIS
  // time fields stay in range
  a_time_range: assert property (@(posedge clk) disable iff (!rst_n)
    (hr_r < 5'd24) && (min_r < 6'd60) && (sec_r < 6'd60))
    else $error("time field out of range");

  // an accepted word always shows up at the output next cycle
  a_accept_out: assert property (@(posedge clk) disable iff (!rst_n)
    accept |=> out_valid_r)
    else $error("accepted word missing at output");

  // a stalled output word blocks new input
  a_stall_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && !out_ready) |-> !in_ready)
    else $error("input taken while output stalled");

  // a set mode never shows the temperature minus sign on the frame
  a_set_shows_time: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_word_r.set_mode != MODE_NORMAL) |-> out_word_r.digit_one != SEG_MINUS)
    else $error("temperature frame in set mode");

  // stored temperature digits are decimal
  a_temp_digits: assert property (@(posedge clk) disable iff (!rst_n)
    (t_hund_r < 4'd10) && (t_tens_r < 4'd10) && (t_ones_r < 4'd10))
    else $error("stored temperature digit out of range");
`endif

endmodule
